[hw/rtl/properties_text_tokenizer_top_assert.svh]
// Assertion macros shared by the properties text tokenizer modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef PROPERTIES_TEXT_TOKENIZER_TOP_ASSERT_SVH
`define PROPERTIES_TEXT_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication
`define PTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PTT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/ptt_pkg.sv]
// Types, character codes and helpers of the properties text tokenizer.
// Depends on nothing; imported by every module of the block.
package ptt_pkg;

	localparam int CHAR_W = 16;
	localparam int KIND_W = 3;

	localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
	localparam logic [CHAR_W-1:0] CH_LF    = 16'h000A;
	localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
	localparam logic [CHAR_W-1:0] CH_BANG  = 16'h0021;
	localparam logic [CHAR_W-1:0] CH_HASH  = 16'h0023;
	localparam logic [CHAR_W-1:0] CH_COLON = 16'h003A;
	localparam logic [CHAR_W-1:0] CH_EQ    = 16'h003D;
	localparam logic [CHAR_W-1:0] CH_BSL   = 16'h005C;
	localparam logic [CHAR_W-1:0] CH_UC_U  = 16'h0055;
	localparam logic [CHAR_W-1:0] CH_LC_U  = 16'h0075;
	localparam logic [CHAR_W-1:0] CH_LC_T  = 16'h0074;
	localparam logic [CHAR_W-1:0] CH_LC_N  = 16'h006E;
	localparam logic [CHAR_W-1:0] CH_LC_R  = 16'h0072;

	typedef enum logic [KIND_W-1:0] {
		KIND_KEY     = 3'd0,
		KIND_KEY_END = 3'd1,
		KIND_VAL     = 3'd2,
		KIND_REC_END = 3'd3,
		KIND_ABORT   = 3'd4
	} kind_t;

	typedef enum logic [6:0] {
		PH_SKIP    = 7'b0000001,
		PH_COMMENT = 7'b0000010,
		PH_KEY     = 7'b0000100,
		PH_VAL     = 7'b0001000,
		PH_ESC     = 7'b0010000,
		PH_CONT    = 7'b0100000,
		PH_HEX     = 7'b1000000
	} phase_t;

	// direct: emit at once and drop held blanks; else put through the trim buffer
	typedef struct packed {
		logic              valid;
		logic              direct;
		kind_t             kind;
		logic [CHAR_W-1:0] sym;
	} op_t;

	typedef enum logic [2:0] {
		ACT_NONE       = 3'd0,
		ACT_APPEND     = 3'd1,
		ACT_OVF_APPEND = 3'd2,
		ACT_FLUSH      = 3'd3,
		ACT_EMIT_SYM   = 3'd4,
		ACT_EMIT_CLR   = 3'd5
	} act_t;

	typedef struct packed {
		logic load;
		logic in_op2;
		act_t act;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic direct;
		logic blank;
		logic suppress;
	} op_stat_t;

	typedef struct packed {
		op_stat_t op1;
		op_stat_t op2;
		logic     held_empty;
		logic     held_full;
		logic     out_free;
	} stat_t;

	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic is_eol(input logic [CHAR_W-1:0] c);
		return (c == CH_LF) || (c == CH_CR);
	endfunction

endpackage

[hw/rtl/ptt_decode.sv]
// Character decoder: parse phase transition and the ops that one item causes.
// Depends on ptt_pkg.
module ptt_decode
	import ptt_pkg::*;
(
	input  logic [CHAR_W-1:0] ch,
	input  logic              eoi,
	input  phase_t            ph,
	input  logic [2:0]        hcnt,
	input  logic [CHAR_W-1:0] hacc,
	output phase_t            ph_next,
	output logic [2:0]        hcnt_next,
	output logic [CHAR_W-1:0] hacc_next,
	output op_t               op1,
	output op_t               op2
);

	localparam logic [2:0] HEX_DIGITS = 3'd4;

	function automatic op_t mk_op(input logic direct, input kind_t kind,
		input logic [CHAR_W-1:0] sym);
		op_t o;
		o.valid  = 1'b1;
		o.direct = direct;
		o.kind   = kind;
		o.sym    = sym;
		return o;
	endfunction

	logic       hex_ok;
	logic [3:0] hex_val;
	logic [2:0] hcnt_inc;
	logic [CHAR_W-1:0] hacc_sh;

	always_comb begin
		hex_ok  = 1'b0;
		hex_val = ch[3:0];
		if (ch >= 16'h0030 && ch <= 16'h0039) begin
			hex_ok = 1'b1;
		end else if ((ch >= 16'h0061 && ch <= 16'h0066) || (ch >= 16'h0041 && ch <= 16'h0046)) begin
			hex_ok  = 1'b1;
			hex_val = ch[3:0] + 4'd9;
		end
	end

	assign hcnt_inc = hcnt + 3'd1;
	assign hacc_sh  = {hacc[CHAR_W-5:0], hex_val};

	always_comb begin
		ph_next   = ph;
		hcnt_next = hcnt;
		hacc_next = hacc;
		op1       = '0;
		op2       = '0;
		if (eoi) begin
			ph_next   = PH_SKIP;
			hcnt_next = '0;
			hacc_next = '0;
			unique case (ph) inside
				PH_KEY: op1 = mk_op(1'b1, KIND_ABORT, '0);
				PH_HEX: begin
					op1 = mk_op(1'b0, KIND_VAL, hacc);
					op2 = mk_op(1'b1, KIND_REC_END, '0);
				end
				PH_VAL, PH_ESC, PH_CONT: op1 = mk_op(1'b1, KIND_REC_END, '0);
				default: ;
			endcase
		end else begin
			unique case (ph)
				PH_COMMENT: if (is_eol(ch)) ph_next = PH_SKIP;
				PH_KEY: begin
					if (ch == CH_EQ || ch == CH_COLON) begin
						op1     = mk_op(1'b1, KIND_KEY_END, '0);
						ph_next = PH_VAL;
					end else begin
						op1 = mk_op(1'b0, KIND_KEY, ch);
					end
				end
				PH_VAL: begin
					if (is_eol(ch)) begin
						op1     = mk_op(1'b1, KIND_REC_END, '0);
						ph_next = PH_SKIP;
					end else if (ch == CH_BSL) begin
						ph_next = PH_ESC;
					end else begin
						op1 = mk_op(1'b0, KIND_VAL, ch);
					end
				end
				PH_ESC: begin
					ph_next = PH_VAL;
					if (is_eol(ch)) begin
						ph_next = PH_CONT;
					end else if (ch == CH_LC_U || ch == CH_UC_U) begin
						ph_next   = PH_HEX;
						hcnt_next = '0;
						hacc_next = '0;
					end else if (ch == CH_LC_T) begin
						op1 = mk_op(1'b0, KIND_VAL, CH_TAB);
					end else if (ch == CH_LC_N) begin
						op1 = mk_op(1'b0, KIND_VAL, CH_LF);
					end else if (ch == CH_LC_R) begin
						op1 = mk_op(1'b0, KIND_VAL, CH_CR);
					end else begin
						op1 = mk_op(1'b0, KIND_VAL, ch);
					end
				end
				PH_CONT: begin
					if (!is_blank(ch) && !is_eol(ch)) begin
						op1     = mk_op(1'b0, KIND_VAL, ch);
						ph_next = PH_VAL;
					end
				end
				PH_HEX: begin
					if (hex_ok) begin
						hacc_next = hacc_sh;
						hcnt_next = hcnt_inc;
						if (hcnt_inc >= HEX_DIGITS) begin
							op1       = mk_op(1'b0, KIND_VAL, hacc_sh);
							hcnt_next = '0;
							ph_next   = PH_VAL;
						end
					end else begin
						op1       = mk_op(1'b0, KIND_VAL, hacc);
						hcnt_next = '0;
						ph_next   = PH_VAL;
						if (is_eol(ch)) begin
							op2     = mk_op(1'b1, KIND_REC_END, '0);
							ph_next = PH_SKIP;
						end else if (ch == CH_BSL) begin
							ph_next = PH_ESC;
						end else begin
							op2 = mk_op(1'b0, KIND_VAL, ch);
						end
					end
				end
				default: begin
					ph_next = PH_SKIP;
					if (is_blank(ch) || is_eol(ch)) begin
						ph_next = PH_SKIP;
					end else if (ch == CH_HASH || ch == CH_BANG) begin
						ph_next = PH_COMMENT;
					end else if (ch == CH_EQ || ch == CH_COLON) begin
						op1     = mk_op(1'b1, KIND_KEY_END, '0);
						ph_next = PH_VAL;
					end else begin
						op1     = mk_op(1'b1, KIND_KEY, ch);
						ph_next = PH_KEY;
					end
				end
			endcase
		end
	end

endmodule

[hw/rtl/ptt_dpath.sv]
// Datapath: parse state, op registers, held blank buffer and output register.
// Depends on ptt_pkg, ptt_decode and the assertion macro header.
`include "properties_text_tokenizer_top_assert.svh"

module ptt_dpath
	import ptt_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CHAR_W-1:0] s_tdata,
	input  logic              s_tuser,
	output logic [CHAR_W-1:0] m_tdata,
	output logic [3:0]        m_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic              m_tlast,
	input  cmd_t              cmd,
	output stat_t             st
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	phase_t            ph_q, ph_d;
	logic [2:0]        hcnt_q, hcnt_d;
	logic [CHAR_W-1:0] hacc_q, hacc_d;
	op_t               op1_q, op2_q, op1_d, op2_d, cur;
	logic [DEPTH-1:0]  held_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              vs_q;

	logic              out_valid_q, ovf_q, last_q;
	kind_t             kind_q;
	logic [CHAR_W-1:0] sym_q;

	logic              cur_tab, emit, final_emit, vs_post, op2_emits, last_d;
	logic              ovf_d;
	logic [CHAR_W-1:0] sym_d;

	ptt_decode u_decode (
		.ch        (s_tdata),
		.eoi       (s_tuser),
		.ph        (ph_q),
		.hcnt      (hcnt_q),
		.hacc      (hacc_q),
		.ph_next   (ph_d),
		.hcnt_next (hcnt_d),
		.hacc_next (hacc_d),
		.op1       (op1_d),
		.op2       (op2_d)
	);

	function automatic op_stat_t op_status(input op_t o, input logic vs);
		op_stat_t s;
		s.valid    = o.valid;
		s.direct   = o.direct;
		s.blank    = is_blank(o.sym);
		s.suppress = is_blank(o.sym) && (o.kind == KIND_VAL) && !vs;
		return s;
	endfunction

	assign cur     = cmd.in_op2 ? op2_q : op1_q;
	assign cur_tab = (cur.sym == CH_TAB);

	always_comb begin
		st.op1        = op_status(op1_q, vs_q);
		st.op2        = op_status(op2_q, vs_q);
		st.held_empty = (cnt_q == '0);
		st.held_full  = (cnt_q >= CNT_FULL);
		st.out_free   = !out_valid_q || m_tready;
	end

	// last flag: look at what the second op would emit after this one
	always_comb begin
		emit       = 1'b0;
		final_emit = 1'b0;
		ovf_d      = 1'b0;
		sym_d      = cur.sym;
		vs_post    = vs_q;
		unique case (cmd.act)
			ACT_OVF_APPEND: begin
				emit       = 1'b1;
				final_emit = 1'b1;
				ovf_d      = 1'b1;
				sym_d      = held_q[0] ? CH_TAB : CH_SPACE;
			end
			ACT_FLUSH: begin
				emit  = 1'b1;
				sym_d = held_q[0] ? CH_TAB : CH_SPACE;
			end
			ACT_EMIT_SYM: begin
				emit       = 1'b1;
				final_emit = 1'b1;
				vs_post    = vs_q || (cur.kind == KIND_VAL);
			end
			ACT_EMIT_CLR: begin
				emit       = 1'b1;
				final_emit = 1'b1;
				vs_post    = 1'b0;
			end
			default: ;
		endcase
		op2_emits = op2_q.valid && (op2_q.direct || !is_blank(op2_q.sym) ||
			(((op2_q.kind != KIND_VAL) || vs_post) && (cmd.act == ACT_OVF_APPEND)));
		last_d = final_emit && (cmd.in_op2 || !op2_emits);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_SKIP;
			hcnt_q <= '0;
			hacc_q <= '0;
			op1_q  <= '0;
			op2_q  <= '0;
			cnt_q  <= '0;
			vs_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				ph_q   <= ph_d;
				hcnt_q <= hcnt_d;
				hacc_q <= hacc_d;
				op1_q  <= op1_d;
				op2_q  <= op2_d;
			end
			unique case (cmd.act)
				ACT_APPEND:   cnt_q <= cnt_q + CNT_W'(1);
				ACT_FLUSH:    cnt_q <= cnt_q - CNT_W'(1);
				ACT_EMIT_SYM: vs_q  <= vs_post;
				ACT_EMIT_CLR: begin
					cnt_q <= '0;
					vs_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.act)
			ACT_APPEND: begin
				for (int i = 0; i < DEPTH; i++) begin
					if (cnt_q == CNT_W'(i)) held_q[i] <= cur_tab;
				end
			end
			ACT_OVF_APPEND: begin
				for (int i = 0; i < DEPTH - 1; i++) held_q[i] <= held_q[i+1];
				held_q[DEPTH-1] <= cur_tab;
			end
			ACT_FLUSH: begin
				for (int i = 0; i < DEPTH - 1; i++) held_q[i] <= held_q[i+1];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= cur.kind;
			sym_q  <= sym_d;
			ovf_q  <= ovf_d;
			last_q <= last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = sym_q;
	assign m_tuser  = {ovf_q, kind_q};
	assign m_tlast  = last_q;

	`PTT_ASSERT_IMP(a_ovf_blank, clk, arst_n, out_valid_q && ovf_q, (sym_q == CH_SPACE) || (sym_q == CH_TAB), "overflow item is not a blank")
	`PTT_ASSERT_IMP(a_flush_nonempty, clk, arst_n, cmd.act == ACT_FLUSH, cnt_q != '0, "flush from an empty held buffer")
	`PTT_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_FULL, "held count beyond depth")

endmodule

[hw/rtl/ptt_ctrl.sv]
// Controller: accepts an item, then sequences its ops one result per cycle while the output is free.
// Depends on ptt_pkg and the assertion macro header.
`include "properties_text_tokenizer_top_assert.svh"

module ptt_ctrl
	import ptt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t st,
	output cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_OP1  = 3'b010,
		S_OP2  = 3'b100
	} state_t;

	state_t   state_q, state_d;
	op_stat_t os;
	logic     advance;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.act    = ACT_NONE;
		cmd.in_op2 = (state_q == S_OP2);
		os         = cmd.in_op2 ? st.op2 : st.op1;
		advance    = 1'b0;
		state_d    = state_q;
		if (state_q != S_IDLE) begin
			if (!os.valid) begin
				advance = 1'b1;
			end else if (os.direct) begin
				if (st.out_free) begin
					cmd.act = ACT_EMIT_CLR;
					advance = 1'b1;
				end
			end else if (os.blank) begin
				if (os.suppress) begin
					advance = 1'b1;
				end else if (!st.held_full) begin
					cmd.act = ACT_APPEND;
					advance = 1'b1;
				end else if (st.out_free) begin
					cmd.act = ACT_OVF_APPEND;
					advance = 1'b1;
				end
			end else if (!st.held_empty) begin
				if (st.out_free) cmd.act = ACT_FLUSH;
			end else if (st.out_free) begin
				cmd.act = ACT_EMIT_SYM;
				advance = 1'b1;
			end
		end
		unique case (state_q)
			S_IDLE: begin
				cmd.load = s_tvalid;
				if (s_tvalid) state_d = S_OP1;
			end
			S_OP1: if (advance) state_d = st.op2.valid ? S_OP2 : S_IDLE;
			S_OP2: if (advance) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`PTT_ASSERT_IMP(a_emit_free, clk, arst_n, (cmd.act == ACT_OVF_APPEND) || (cmd.act == ACT_FLUSH) || (cmd.act == ACT_EMIT_SYM) || (cmd.act == ACT_EMIT_CLR), st.out_free, "result issued while output busy")
	`PTT_ASSERT_NXT(a_load_op1, clk, arst_n, cmd.load, state_q == S_OP1, "accepted item not sequenced")
	`PTT_ASSERT_IMP(a_op2_valid, clk, arst_n, state_q == S_OP2, st.op2.valid, "second op step without a second op")

endmodule

[hw/rtl/properties_text_tokenizer_top.sv]
// Properties text tokenizer, top level: controller plus datapath.
// Depends on ptt_pkg, ptt_ctrl, ptt_dpath.
//
// Takes one UTF-16 code unit (or an end mark in s_tuser) per item and streams
// tagged key and value characters of key = value records; m_tlast marks the
// final result caused by an item. An item is accepted in the idle state and then
// takes one op step, a second when a \u escape is closed by a following character
// other than a backslash or by the end mark, plus one flush step per held trailing
// blank written out before a non-blank character; the op sequencer issues a single
// result per cycle into one output register, and a stalled output holds the
// sequence.
// The held blank buffer needs no clearing pass after reset.
module properties_text_tokenizer_top
	import ptt_pkg::*;
#(
	parameter int HELD_BLANK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] character
	input  logic        s_tuser,   // [0] end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] symbol
	output logic [3:0]  m_tuser,   // [2:0] kind, [3] trim_overflow
	output logic        m_tlast
);

	cmd_t  cmd;
	stat_t st;

	ptt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	ptt_dpath #(
		.DEPTH (HELD_BLANK_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.st       (st)
	);

endmodule

[verif/ptt_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the properties text tokenizer: predicts the tagged results caused
// by every accepted character or end mark and compares them with the output.
// Depends on ptt_pkg for the character codes, the phases and the result kinds.
module ptt_checker
	import ptt_pkg::*;
#(
	parameter int HELD_BLANK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [CHAR_W-1:0] s_tdata,
	input  logic              s_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [CHAR_W-1:0] m_tdata,
	input  logic [3:0]        m_tuser,
	input  logic              m_tlast,
	output int                errors,
	output int                outstanding,
	output int                checked,
	output int                overflows,
	output int                aborts
);

	typedef struct packed {
		kind_t             kind;
		logic [CHAR_W-1:0] sym;
		logic              ovf;
		logic              last;
	} token_t;

	token_t expected_tokens[$];
	token_t step_tokens[$];

	phase_t            ph;
	logic [2:0]        hex_n;
	logic [CHAR_W-1:0] hex_acc;
	logic              held_tab [HELD_BLANK_DEPTH];
	int                held_n;
	logic              val_started;
	int                n_err;
	int                n_checked;
	int                n_ovf;
	int                n_abort;

	function automatic logic blank_char(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic line_break(input logic [CHAR_W-1:0] c);
		return (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic int hex_value(input logic [CHAR_W-1:0] c);
		if (c >= 16'h0030 && c <= 16'h0039) return int'(c) - 'h30;
		if (c >= 16'h0061 && c <= 16'h0066) return int'(c) - 'h61 + 10;
		if (c >= 16'h0041 && c <= 16'h0046) return int'(c) - 'h41 + 10;
		return -1;
	endfunction

	function automatic void emit_token(input kind_t k, input logic [CHAR_W-1:0] c,
			input logic o);
		token_t t;
		t.kind = k;
		t.sym = c;
		t.ovf = o;
		t.last = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void hold_blank(input kind_t k, input logic [CHAR_W-1:0] c);
		if (held_n >= HELD_BLANK_DEPTH) begin
			emit_token(k, held_tab[0] ? CH_TAB : CH_SPACE, 1'b1);
			for (int i = 1; i < HELD_BLANK_DEPTH; i++)
				held_tab[i-1] = held_tab[i];
			held_n = HELD_BLANK_DEPTH - 1;
		end
		held_tab[held_n] = (c == CH_TAB);
		held_n++;
	endfunction

	function automatic void flush_blanks(input kind_t k);
		for (int i = 0; i < held_n; i++)
			emit_token(k, held_tab[i] ? CH_TAB : CH_SPACE, 1'b0);
		held_n = 0;
	endfunction

	function automatic void key_char(input logic [CHAR_W-1:0] c);
		if (blank_char(c)) begin
			hold_blank(KIND_KEY, c);
		end else begin
			flush_blanks(KIND_KEY);
			emit_token(KIND_KEY, c, 1'b0);
		end
	endfunction

	function automatic void value_char(input logic [CHAR_W-1:0] c);
		if (blank_char(c)) begin
			if (val_started)
				hold_blank(KIND_VAL, c);
		end else begin
			flush_blanks(KIND_VAL);
			emit_token(KIND_VAL, c, 1'b0);
			val_started = 1'b1;
		end
	endfunction

	function automatic void open_value();
		emit_token(KIND_KEY_END, '0, 1'b0);
		held_n = 0;
		val_started = 1'b0;
		ph = PH_VAL;
	endfunction

	function automatic void close_record();
		held_n = 0;
		emit_token(KIND_REC_END, '0, 1'b0);
		val_started = 1'b0;
		ph = PH_SKIP;
	endfunction

	function automatic void plain_value_char(input logic [CHAR_W-1:0] c);
		if (line_break(c))
			close_record();
		else if (c == CH_BSL)
			ph = PH_ESC;
		else
			value_char(c);
	endfunction

	function automatic void tokenize(input logic [CHAR_W-1:0] c, input logic eoi);
		int     d;
		token_t t;
		step_tokens.delete();
		if (eoi) begin
			case (ph)
				PH_KEY: begin
					held_n = 0;
					emit_token(KIND_ABORT, '0, 1'b0);
				end
				PH_HEX: begin
					value_char(hex_acc);
					close_record();
				end
				PH_VAL, PH_ESC, PH_CONT: close_record();
				default: ;
			endcase
			ph = PH_SKIP;
			hex_n = '0;
			hex_acc = '0;
			held_n = 0;
			val_started = 1'b0;
		end else begin
			case (ph)
				PH_COMMENT: if (line_break(c)) ph = PH_SKIP;
				PH_KEY: begin
					if (c == CH_EQ || c == CH_COLON)
						open_value();
					else
						key_char(c);
				end
				PH_VAL: plain_value_char(c);
				PH_ESC: begin
					ph = PH_VAL;
					if (line_break(c)) begin
						ph = PH_CONT;
					end else if (c == CH_LC_U || c == CH_UC_U) begin
						ph = PH_HEX;
						hex_n = '0;
						hex_acc = '0;
					end else if (c == CH_LC_T) begin
						value_char(CH_TAB);
					end else if (c == CH_LC_N) begin
						value_char(CH_LF);
					end else if (c == CH_LC_R) begin
						value_char(CH_CR);
					end else begin
						value_char(c);
					end
				end
				PH_CONT: begin
					if (!blank_char(c) && !line_break(c)) begin
						value_char(c);
						ph = PH_VAL;
					end
				end
				PH_HEX: begin
					d = hex_value(c);
					if (d >= 0) begin
						hex_acc = {hex_acc[11:0], d[3:0]};
						hex_n = hex_n + 3'd1;
						if (hex_n >= 3'd4) begin
							value_char(hex_acc);
							hex_n = '0;
							ph = PH_VAL;
						end
					end else begin
						value_char(hex_acc);
						hex_n = '0;
						ph = PH_VAL;
						plain_value_char(c);
					end
				end
				default: begin
					ph = PH_SKIP;
					if (blank_char(c) || line_break(c)) begin
					end else if (c == CH_HASH || c == CH_BANG) begin
						ph = PH_COMMENT;
					end else if (c == CH_EQ || c == CH_COLON) begin
						open_value();
					end else begin
						held_n = 0;
						emit_token(KIND_KEY, c, 1'b0);
						ph = PH_KEY;
					end
				end
			endcase
		end
		if (step_tokens.size() > 0) begin
			t = step_tokens[step_tokens.size()-1];
			t.last = 1'b1;
			step_tokens[step_tokens.size()-1] = t;
		end
		foreach (step_tokens[i])
			expected_tokens.push_back(step_tokens[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		token_t want;
		if (!arst_n) begin
			ph = PH_SKIP;
			hex_n = '0;
			hex_acc = '0;
			held_n = 0;
			val_started = 1'b0;
			for (int i = 0; i < HELD_BLANK_DEPTH; i++)
				held_tab[i] = 1'b0;
			expected_tokens.delete();
			n_err = 0;
			n_checked = 0;
			n_ovf = 0;
			n_abort = 0;
			errors <= 0;
			outstanding <= 0;
			checked <= 0;
			overflows <= 0;
			aborts <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_checked++;
				if (m_tuser[3])
					n_ovf++;
				if (m_tuser[2:0] == KIND_ABORT)
					n_abort++;
				if (expected_tokens.size() == 0) begin
					$error("result with nothing expected: kind %0d symbol %h",
						m_tuser[2:0], m_tdata);
					n_err++;
				end else begin
					want = expected_tokens.pop_front();
					if (m_tuser[2:0] !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, m_tuser[2:0]);
						n_err++;
					end
					if (m_tdata !== want.sym) begin
						$error("symbol: expected %h, got %h", want.sym, m_tdata);
						n_err++;
					end
					if (m_tuser[3] !== want.ovf) begin
						$error("trim_overflow: expected %0d, got %0d", want.ovf, m_tuser[3]);
						n_err++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, m_tlast);
						n_err++;
					end
				end
			end
			if (s_tvalid && s_tready)
				tokenize(s_tdata, s_tuser);
			errors <= n_err;
			outstanding <= expected_tokens.size();
			checked <= n_checked;
			overflows <= n_ovf;
			aborts <= n_abort;
		end
	end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the properties text tokenizer: clock, reset, text stimulus,
// flow control on both streams and the verdict. Depends on ptt_pkg,
// properties_text_tokenizer_top and ptt_checker.
module tb
	import ptt_pkg::*;
();

	localparam int HELD_BLANK_DEPTH = 16;
	localparam logic [CHAR_W-1:0] CH_ZERO = 16'h0030;
	localparam logic [CHAR_W-1:0] CH_LC_A = 16'h0061;
	localparam logic [CHAR_W-1:0] CH_UC_A = 16'h0041;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [CHAR_W-1:0] s_tdata = '0;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [CHAR_W-1:0] m_tdata;
	logic [3:0]        m_tuser;
	logic              m_tlast;

	int errors;
	int outstanding;
	int checked;
	int overflows;
	int aborts;

	int send_idle = 22;
	int recv_idle = 88;
	int choke_ask = 0;
	int choke_taken = 0;
	int choke_left = 0;
	int n_sent = 0;
	int n_useful = 0;
	int target;

	logic [CHAR_W:0] pending_text[$];

	always #1 clk = ~clk;

	properties_text_tokenizer_top #(
		.HELD_BLANK_DEPTH(HELD_BLANK_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	ptt_checker #(
		.HELD_BLANK_DEPTH(HELD_BLANK_DEPTH)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.errors(errors),
		.outstanding(outstanding),
		.checked(checked),
		.overflows(overflows),
		.aborts(aborts)
	);

	always @(negedge clk) begin
		if (choke_left != 0) begin
			m_tready <= 1'b0;
			choke_left <= choke_left - 1;
		end else if (choke_ask != choke_taken) begin
			m_tready <= 1'b0;
			choke_left <= 400;
			choke_taken <= choke_ask;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	function automatic void put_char(input logic [CHAR_W-1:0] c);
		pending_text.push_back({1'b0, c});
		n_useful++;
	endfunction

	function automatic void put_ignored(input logic [CHAR_W-1:0] c);
		pending_text.push_back({1'b0, c});
	endfunction

	function automatic void put_end();
		pending_text.push_back({1'b1, {CHAR_W{1'b0}}});
		n_useful++;
	endfunction

	function automatic logic [CHAR_W-1:0] letter();
		logic [CHAR_W-1:0] r;
		r = CHAR_W'($urandom_range(25));
		return ($urandom_range(1) != 0) ? CH_LC_A + r : CH_UC_A + r;
	endfunction

	function automatic logic [CHAR_W-1:0] any_word();
		logic [CHAR_W-1:0] w;
		w = CHAR_W'($urandom_range(16'hFFFF));
		return w;
	endfunction

	function automatic logic [CHAR_W-1:0] hex_digit();
		logic [CHAR_W-1:0] k;
		k = CHAR_W'($urandom_range(21));
		if (k < 16'd10)
			return CH_ZERO + k;
		if (k < 16'd16)
			return CH_LC_A + k - 16'd10;
		return CH_UC_A + k - 16'd16;
	endfunction

	function automatic logic [CHAR_W-1:0] blank();
		return ($urandom_range(1) != 0) ? CH_TAB : CH_SPACE;
	endfunction

	function automatic void put_blanks(input int n);
		repeat (n) put_char(blank());
	endfunction

	function automatic logic [CHAR_W-1:0] noise_char();
		case ($urandom_range(11))
			0: return CH_EQ;
			1: return CH_COLON;
			2: return CH_HASH;
			3: return CH_BANG;
			4: return CH_BSL;
			5: return CH_LC_U;
			6: return CH_LF;
			7: return CH_CR;
			8: return CH_SPACE;
			9: return CH_TAB;
			10: return hex_digit();
			default: return any_word();
		endcase
	endfunction

	function automatic void make_record();
		int                pick;
		int                n;
		logic [CHAR_W-1:0] c;
		repeat ($urandom_range(2)) begin
			pick = $urandom_range(3);
			put_ignored(pick == 0 ? CH_SPACE : pick == 1 ? CH_TAB : pick == 2 ? CH_LF : CH_CR);
		end
		pick = $urandom_range(99);
		if (pick < 8) begin
			put_ignored(($urandom_range(1) != 0) ? CH_HASH : CH_BANG);
			repeat ($urandom_range(5)) put_ignored(letter());
			put_ignored(($urandom_range(1) != 0) ? CH_LF : CH_CR);
			return;
		end
		if (pick < 16) begin
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(9) == 0)
					put_end();
				else
					put_char(noise_char());
			end
			return;
		end
		if ($urandom_range(9) != 0) begin
			c = letter();
			if ($urandom_range(3) == 0) begin
				c = any_word();
				if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
						c == CH_HASH || c == CH_BANG || c == CH_EQ || c == CH_COLON)
					c = CH_LC_A;
			end
			put_char(c);
			repeat ($urandom_range(4)) begin
				pick = $urandom_range(9);
				if (pick < 5)
					put_char(letter());
				else if (pick < 8)
					put_blanks($urandom_range(1, 3));
				else if (pick < 9)
					put_char(any_word());
				else
					put_blanks($urandom_range(14, 20));
			end
			if ($urandom_range(14) == 0) begin
				put_end();
				return;
			end
			put_blanks($urandom_range(2));
		end
		put_char(($urandom_range(1) != 0) ? CH_EQ : CH_COLON);
		put_blanks($urandom_range(2));
		repeat ($urandom_range(8)) begin
			case ($urandom_range(9))
				3: put_char(any_word());
				4: put_blanks(($urandom_range(9) == 0) ? $urandom_range(15, 20) :
					$urandom_range(1, 3));
				5: begin
					put_char(CH_BSL);
					case ($urandom_range(3))
						0: put_char(CH_LC_T);
						1: put_char(CH_LC_N);
						2: put_char(CH_LC_R);
						default: put_char(letter());
					endcase
				end
				6: begin
					put_char(CH_BSL);
					put_char(($urandom_range(1) != 0) ? CH_LC_U : CH_UC_U);
					n = $urandom_range(4);
					repeat (n) put_char(hex_digit());
					if (n < 4 && $urandom_range(1) != 0)
						put_char(letter());
				end
				7: begin
					put_char(CH_BSL);
					put_char(($urandom_range(1) != 0) ? CH_LF : CH_CR);
					put_blanks($urandom_range(3));
					put_char(letter());
				end
				8: begin
					put_char(CH_BSL);
					put_char(blank());
				end
				default: put_char(letter());
			endcase
		end
		put_blanks($urandom_range(2));
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: put_char(CH_LF);
			6: put_char(CH_CR);
			7: put_end();
			8: begin
				put_char(CH_BSL);
				put_end();
			end
			default: begin
				put_char(CH_BSL);
				if ($urandom_range(1) != 0) begin
					put_char(CH_LC_U);
					put_char(hex_digit());
				end else begin
					put_char(CH_LF);
				end
				put_end();
			end
		endcase
	endfunction

	task automatic send_text();
		logic [CHAR_W:0] e;
		while (pending_text.size() != 0) begin
			e = pending_text.pop_front();
			@(negedge clk);
			while ($urandom_range(99) < send_idle) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= e[CHAR_W-1:0];
			s_tuser <= e[CHAR_W];
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			n_sent++;
		end
	endtask

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// empty key with a backslash at end of input, end in a comment, end between records
		put_char(CH_EQ);
		put_char(CH_BSL);
		put_end();
		put_char(CH_HASH);
		put_end();
		put_end();
		// abort inside a key with a held blank
		put_char(16'hFFFF);
		put_char(CH_SPACE);
		put_end();
		// short hex escape, tab escape, line continuation, end inside a hex escape
		put_char(16'h0000);
		put_char(CH_COLON);
		put_char(CH_SPACE);
		put_char(CH_BSL);
		put_char(CH_LC_U);
		put_char(CH_ZERO + 16'd4);
		put_char(CH_ZERO + 16'd1);
		put_char(CH_LC_A + 16'd25);
		put_char(CH_BSL);
		put_char(CH_LC_T);
		put_char(CH_BSL);
		put_char(CH_LF);
		put_char(CH_TAB);
		put_char(CH_LC_A + 16'd24);
		put_char(CH_BSL);
		put_char(CH_UC_U);
		put_char(CH_ZERO + 16'd7);
		put_end();
		send_text();

		target = n_useful + 65;
		while (n_useful < target) begin
			make_record();
			send_text();
		end

		send_idle = 88;
		recv_idle <= 22;
		target = n_useful + 65;
		while (n_useful < target) begin
			make_record();
			send_text();
		end

		send_idle = 0;
		recv_idle <= 0;
		choke_ask <= choke_ask + 1;
		put_char(CH_LC_A + 16'd10);
		put_char(CH_EQ);
		repeat (60) put_char(letter());
		put_char(CH_LF);
		send_text();
		target = n_useful + 65;
		while (n_useful < target) begin
			make_record();
			send_text();
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Sent %0d characters and end marks; checked %0d results,", n_sent, checked);
		$display("among them %0d early blank flushes and %0d aborted records.",
			overflows, aborts);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
